### hdl/sga_pkg.sv
// ----------------------------------------------------------------------------
// sga_pkg
// Shared types, constants and arithmetic helpers of the statevector engine.
// ----------------------------------------------------------------------------
package sga_pkg;

	localparam int MaxQubits  = 10;
	localparam int PartWidth  = 32;
	localparam int FracBits   = PartWidth - 2;
	localparam int Depth      = 1 << MaxQubits;
	localparam int GateDepth  = 16;
	localparam int AddrW      = MaxQubits;
	localparam int ProdW      = 2 * PartWidth;
	localparam int AccW       = PartWidth + 6;

	typedef logic [1:0] mode_t;
	localparam mode_t ModeWrAmp  = 2'd0;
	localparam mode_t ModeWrGate = 2'd1;
	localparam mode_t ModeApply  = 2'd2;
	localparam mode_t ModeRdAmp  = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t StOk    = 2'd0;
	localparam status_t StRange = 2'd1;
	localparam status_t StEqual = 2'd2;
	localparam status_t StSat   = 2'd3;

	localparam logic [1:0] RegQubits = 2'd0;
	localparam logic [1:0] RegTwoQ   = 2'd1;
	localparam logic [1:0] RegFirst  = 2'd2;
	localparam logic [1:0] RegSecond = 2'd3;

	typedef logic signed [PartWidth-1:0] part_t;

	typedef struct packed {
		part_t re;
		part_t im;
	} cplx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_STORE,
		ST_RESULT
	} state_t;

	// control word that goes with each entry fed to the multiply-accumulate unit
	typedef struct packed {
		logic        start;
		logic        valid;
		logic        last;
		logic [1:0]  row;
		logic [1:0]  col;
		logic        two_q;
	} mac_ctl_t;

	// product rounded to the fraction width, half upward
	// (most negative times most negative needs the extra top bit)
	function automatic logic signed [PartWidth+1:0] round_prod(
		input logic signed [ProdW-1:0] p);
		logic signed [ProdW:0] t;
		t = {p[ProdW-1], p} + (ProdW+1)'(1 <<< (FracBits - 1));
		return t[FracBits +: PartWidth+2];
	endfunction

	function automatic part_t sat_part(input logic signed [AccW-1:0] v, output logic hit);
		logic signed [AccW-1:0] hi, lo;
		hi = AccW'(signed'({1'b0, {(PartWidth-1){1'b1}}}));
		lo = -hi - AccW'(1);
		hit = 1'b0;
		if (v > hi) begin
			hit = 1'b1;
			return hi[PartWidth-1:0];
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo[PartWidth-1:0];
		end
		return v[PartWidth-1:0];
	endfunction

endpackage

### hdl/sga_if.sv
// ----------------------------------------------------------------------------
// sga_in_if / sga_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sga_in_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           mode;
	logic [9:0]           index;
	logic signed [31:0]   real_part;
	logic signed [31:0]   imag_part;
	modport source (output valid, mode, index, real_part, imag_part, input ready);
	modport sink (input valid, mode, index, real_part, imag_part, output ready);
endinterface

interface sga_out_if;
	logic                 valid;
	logic                 ready;
	logic signed [31:0]   read_real;
	logic signed [31:0]   read_imag;
	logic [1:0]           status;
	modport source (output valid, read_real, read_imag, status, input ready);
	modport sink (input valid, read_real, read_imag, status, output ready);
endinterface

### hdl/sga_amp_ram.sv
// ----------------------------------------------------------------------------
// sga_amp_ram
// Amplitude memory, one read and one write port, registered read data.
// ----------------------------------------------------------------------------
module sga_amp_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [sga_pkg::AddrW-1:0]     waddr,
	input  sga_pkg::cplx_t                wdata,
	input  logic [sga_pkg::AddrW-1:0]     raddr,
	output sga_pkg::cplx_t                rdata
);
	sga_pkg::cplx_t mem [sga_pkg::Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/sga_mac.sv
// ----------------------------------------------------------------------------
// sga_mac
// Complex multiply-accumulate: one gate entry times one amplitude per cycle,
// four real products registered, then rounded and summed into a row total.
// ----------------------------------------------------------------------------
module sga_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sga_pkg::mac_ctl_t     ctl,
	input  sga_pkg::cplx_t        g,
	input  sga_pkg::cplx_t        a,
	output logic                  done,
	output sga_pkg::cplx_t        res,
	output logic                  sat_hit
);
	logic signed [sga_pkg::ProdW-1:0] rr_s1, ii_s1, ri_s1, ir_s1;
	sga_pkg::mac_ctl_t ctl_s1;
	logic signed [sga_pkg::AccW-1:0] acc_re_q, acc_im_q;
	logic signed [sga_pkg::AccW-1:0] nre, nim;
	logic hr, hi;

	always_ff @(posedge clk) begin
		rr_s1 <= g.re * a.re;
		ii_s1 <= g.im * a.im;
		ri_s1 <= g.re * a.im;
		ir_s1 <= g.im * a.re;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_comb begin
		nre = (ctl_s1.start ? '0 : acc_re_q)
			+ sga_pkg::AccW'(sga_pkg::round_prod(rr_s1))
			- sga_pkg::AccW'(sga_pkg::round_prod(ii_s1));
		nim = (ctl_s1.start ? '0 : acc_im_q)
			+ sga_pkg::AccW'(sga_pkg::round_prod(ri_s1))
			+ sga_pkg::AccW'(sga_pkg::round_prod(ir_s1));
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_re_q <= nre;
			acc_im_q <= nim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s1.valid && ctl_s1.last;
		end
	end

	always_comb begin
		res.re = sga_pkg::sat_part(acc_re_q, hr);
		res.im = sga_pkg::sat_part(acc_im_q, hi);
		sat_hit = hr | hi;
	end
endmodule

### hdl/sga_ctrl.sv
// ----------------------------------------------------------------------------
// sga_ctrl
// Sequencer: walks index groups, loads amplitudes from memory into a group
// buffer, runs the row products through the MAC unit and writes back.
// ----------------------------------------------------------------------------
module sga_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	sga_in_if.sink                    in_ch,
	sga_out_if.source                 out_ch,
	input  logic [3:0]                qubits_q,
	input  logic                      two_q_q,
	input  logic [3:0]                first_q,
	input  logic [3:0]                second_q
);
	localparam int AW = sga_pkg::AddrW;

	sga_pkg::state_t state_q, state_d;
	sga_pkg::cplx_t  gate_q [sga_pkg::GateDepth];
	sga_pkg::cplx_t  grp_q [4];
	sga_pkg::cplx_t  rows_q [4];
	sga_pkg::cplx_t  rdata;

	logic [AW:0]   base_q;
	logic [2:0]    ld_q;
	logic [4:0]    step_q;
	logic [2:0]    wb_q;
	logic          sat_q;
	logic          rd_pend_q;

	logic [3:0]    n_eff;
	logic [AW:0]   dim;
	logic [AW:0]   m1, m2;
	logic [2:0]    gsize;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	sga_pkg::cplx_t wdata;
	logic          accept;
	logic          in_range;
	logic          mac_done, mac_sat;
	sga_pkg::cplx_t mac_res;
	sga_pkg::mac_ctl_t mctl;
	sga_pkg::cplx_t  mg, ma;
	logic [1:0]    mctl_row_s1, mctl_row_done_q;

	logic          res_valid_q;
	sga_pkg::cplx_t res_q;
	sga_pkg::status_t res_st_q;

	assign n_eff = (qubits_q > 4'(sga_pkg::MaxQubits)) ? 4'(sga_pkg::MaxQubits) : qubits_q;
	assign dim   = (AW+1)'(1) << n_eff;
	assign m1    = (AW+1)'(1) << first_q;
	assign m2    = two_q_q ? ((AW+1)'(1) << second_q) : '0;
	assign gsize = two_q_q ? 3'd4 : 3'd2;
	assign accept = in_ch.valid && in_ch.ready;
	assign in_range = (11'(in_ch.index) < 11'(dim));
	// a read holds the input off until its data is back from memory
	assign in_ch.ready = (state_q == sga_pkg::ST_IDLE) && !res_valid_q && !rd_pend_q;

	// address of group member k: bit1 selects m1, bit0 selects m2 (two-qubit)
	function automatic logic [AW-1:0] member(input logic [AW:0] b, input logic [1:0] k,
		input logic tq, input logic [AW:0] a1, input logic [AW:0] a2);
		logic [AW:0] r;
		r = b;
		if (tq) begin
			r = b + (k[1] ? a1 : '0) + (k[0] ? a2 : '0);
		end else begin
			r = b + (k[0] ? a1 : '0);
		end
		return r[AW-1:0];
	endfunction

	// first base after b with all target bits clear
	function automatic logic [AW:0] next_base(input logic [AW:0] b,
		input logic [AW:0] a1, input logic [AW:0] a2);
		logic [AW:0] mask, t;
		mask = a1 | a2;
		t = (b | mask) + (AW+1)'(1);
		return t & ~mask;
	endfunction

	sga_amp_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		mctl = '0;
		mctl.two_q = two_q_q;
		mctl.row = step_q[3:2];
		mctl.col = step_q[1:0];
		if (state_q == sga_pkg::ST_MAC && step_q < 5'(gsize) * 5'(gsize)) begin
			mctl.valid = 1'b1;
			if (two_q_q) begin
				mctl.row = step_q[3:2];
				mctl.col = step_q[1:0];
				mctl.start = (step_q[1:0] == 2'd0);
				mctl.last = (step_q[1:0] == 2'd3);
			end else begin
				mctl.row = {1'b0, step_q[1]};
				mctl.col = {1'b0, step_q[0]};
				mctl.start = !step_q[0];
				mctl.last = step_q[0];
			end
		end
		// column-major: entry index is row + size * col
		mg = gate_q[two_q_q ? {mctl.col, mctl.row} : {2'b00, mctl.col[0], mctl.row[0]}];
		ma = grp_q[mctl.col];
	end

	sga_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mctl),
		.g       (mg),
		.a       (ma),
		.done    (mac_done),
		.res     (mac_res),
		.sat_hit (mac_sat)
	);

	always_comb begin
		we = 1'b0;
		waddr = in_ch.index[AW-1:0];
		wdata = '{re: in_ch.real_part, im: in_ch.imag_part};
		raddr = in_ch.index[AW-1:0];
		if (state_q == sga_pkg::ST_IDLE) begin
			we = accept && in_ch.mode == sga_pkg::ModeWrAmp && in_range;
		end else if (state_q == sga_pkg::ST_LOAD) begin
			raddr = member(base_q, ld_q[1:0], two_q_q, m1, m2);
		end else if (state_q == sga_pkg::ST_STORE) begin
			we = 1'b1;
			waddr = member(base_q, wb_q[1:0], two_q_q, m1, m2);
			wdata = rows_q[wb_q[1:0]];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sga_pkg::ST_IDLE: begin
				if (accept && in_ch.mode == sga_pkg::ModeApply &&
				    !(two_q_q && first_q == second_q) &&
				    !(first_q >= n_eff || (two_q_q && second_q >= n_eff))) begin
					state_d = sga_pkg::ST_LOAD;
				end
			end
			sga_pkg::ST_LOAD: begin
				if (ld_q == gsize) begin
					state_d = sga_pkg::ST_MAC;
				end
			end
			sga_pkg::ST_MAC: begin
				if (step_q == 5'(gsize) * 5'(gsize) + 5'd2) begin
					state_d = sga_pkg::ST_STORE;
				end
			end
			sga_pkg::ST_STORE: begin
				if (wb_q == gsize - 3'd1) begin
					state_d = (next_base(base_q, m1, m2) >= dim) ?
						sga_pkg::ST_RESULT : sga_pkg::ST_LOAD;
				end
			end
			sga_pkg::ST_RESULT: state_d = sga_pkg::ST_IDLE;
			default: state_d = sga_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sga_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// gate store, group buffer and row results; the gate store is small and read at computed addresses by the mac only
	always_ff @(posedge clk) begin
		if (accept && in_ch.mode == sga_pkg::ModeWrGate && in_ch.index < 10'(sga_pkg::GateDepth)) begin
			gate_q[in_ch.index[3:0]] <= '{re: in_ch.real_part, im: in_ch.imag_part};
		end
		if (state_q == sga_pkg::ST_LOAD && ld_q != 3'd0) begin
			grp_q[2'(ld_q - 3'd1)] <= rdata;
		end
		if (mac_done) begin
			rows_q[two_q_q ? mctl_row_done_q : {1'b0, mctl_row_done_q[0]}] <= mac_res;
		end
	end

	// row of the result coming out of the mac, delayed through mctl_row_s1 and mctl_row_done_q to line up with done
	always_ff @(posedge clk) begin
		mctl_row_s1 <= mctl.row;
		mctl_row_done_q <= mctl_row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			ld_q <= '0;
			step_q <= '0;
			wb_q <= '0;
			sat_q <= 1'b0;
			rd_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_st_q <= sga_pkg::StOk;
		end else begin
			rd_pend_q <= 1'b0;
			if (out_ch.valid && out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				sga_pkg::ST_IDLE: begin
					if (accept) begin
						base_q <= next_base('1, m1, m2) & '0;
						ld_q <= '0;
						sat_q <= 1'b0;
						case (in_ch.mode)
							sga_pkg::ModeWrAmp: begin
								res_valid_q <= 1'b1;
								res_st_q <= in_range ? sga_pkg::StOk : sga_pkg::StRange;
							end
							sga_pkg::ModeWrGate: begin
								res_valid_q <= 1'b1;
								res_st_q <= (in_ch.index < 10'(sga_pkg::GateDepth)) ?
									sga_pkg::StOk : sga_pkg::StRange;
							end
							sga_pkg::ModeApply: begin
								if (two_q_q && first_q == second_q) begin
									res_valid_q <= 1'b1;
									res_st_q <= sga_pkg::StEqual;
								end else if (first_q >= n_eff || (two_q_q && second_q >= n_eff)) begin
									res_valid_q <= 1'b1;
									res_st_q <= sga_pkg::StRange;
								end
							end
							default: begin
								if (in_range) begin
									rd_pend_q <= 1'b1;
								end else begin
									res_valid_q <= 1'b1;
									res_st_q <= sga_pkg::StRange;
								end
							end
						endcase
					end
					if (rd_pend_q) begin
						res_valid_q <= 1'b1;
						res_st_q <= sga_pkg::StOk;
					end
				end
				sga_pkg::ST_LOAD: begin
					ld_q <= ld_q + 3'd1;
					step_q <= '0;
				end
				sga_pkg::ST_MAC: begin
					step_q <= step_q + 5'd1;
					wb_q <= '0;
					if (mac_done && mac_sat) begin
						sat_q <= 1'b1;
					end
				end
				sga_pkg::ST_STORE: begin
					wb_q <= wb_q + 3'd1;
					ld_q <= '0;
					if (wb_q == gsize - 3'd1) begin
						base_q <= next_base(base_q, m1, m2);
					end
				end
				sga_pkg::ST_RESULT: begin
					res_valid_q <= 1'b1;
					res_st_q <= sat_q ? sga_pkg::StSat : sga_pkg::StOk;
				end
				default: ;
			endcase
		end
	end

	// read data is captured straight off the memory port
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			res_q <= rdata;
		end else if (state_q == sga_pkg::ST_IDLE && accept) begin
			res_q <= '0;
		end
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.read_real = res_q.re;
	assign out_ch.read_imag = res_q.im;
	assign out_ch.status = res_st_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sga_pkg::ST_IDLE |-> !in_ch.ready)
		else $error("accept while busy");
	a_result_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sga_pkg::ST_RESULT |=> out_ch.valid)
		else $error("apply gave no result");
	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sga_pkg::ST_STORE |-> 11'(waddr) < 11'(dim))
		else $error("write-back outside statevector");
endmodule

### hdl/statevector_gate_apply.sv
// ----------------------------------------------------------------------------
// statevector_gate_apply
// Statevector engine with gate store and APB register port.
// ----------------------------------------------------------------------------
// Amplitude writes, gate writes and rejected items are answered from the idle
// state; a read waits for the registered amplitude memory. An apply walks every
// index group: per pair it loads 2 amplitudes, runs 4 products, drains the MAC
// pipeline and stores 2 rows; per quad it loads 4, runs 16 products and stores
// 4, paced by the single complex MAC unit and the memory's read and write ports;
// after the last group a result item reports the outcome.
module statevector_gate_apply (
	input  logic        clk,
	input  logic        arst_n,
	sga_in_if.sink      in_ch,
	sga_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [3:0] qubits_q, first_q, second_q;
	logic       two_q_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qubits_q <= 4'd10;
			two_q_q <= 1'b0;
			first_q <= 4'd0;
			second_q <= 4'd1;
		end else if (wr) begin
			case (paddr[3:2])
				sga_pkg::RegQubits: qubits_q <= pwdata[3:0];
				sga_pkg::RegTwoQ: two_q_q <= pwdata[0];
				sga_pkg::RegFirst: first_q <= pwdata[3:0];
				sga_pkg::RegSecond: second_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			sga_pkg::RegQubits: prdata = {28'd0, qubits_q};
			sga_pkg::RegTwoQ: prdata = {31'd0, two_q_q};
			sga_pkg::RegFirst: prdata = {28'd0, first_q};
			sga_pkg::RegSecond: prdata = {28'd0, second_q};
			default: prdata = '0;
		endcase
	end

	sga_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.qubits_q (qubits_q),
		.two_q_q  (two_q_q),
		.first_q  (first_q),
		.second_q (second_q)
	);
endmodule
